/* hw/rtl/mf3_pkg.sv */
package mf3_pkg;

    // field widths of the stream items
    localparam int PIX_W = 8;
    localparam int COL_W = 10;
    localparam int ROW_W = 12;
    localparam int HGT_W = 13;
    localparam int FWD_W = 11;
    localparam int SUM_W = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;

    // frame size limits and register reset values
    localparam int MIN_SIZE = 3;
    localparam int MAX_HEIGHT = 4096;
    localparam logic [FWD_W-1:0] WIDTH_RESET = 11'd640;
    localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd480;

    // floor(x / 18) as (x * 7282) >> 17, exact for x below 2^15
    localparam int BOX_X_W = 13;
    localparam logic [BOX_X_W-1:0] BOX_RECIP = 13'd7282;
    localparam logic [BOX_X_W-1:0] BOX_BIAS = 13'd9;
    localparam int BOX_SHIFT = 17;
    localparam int BOX_PROD_W = 2 * BOX_X_W;
    localparam logic [SUM_W-1:0] BIN_BIAS = 12'd8;
    localparam int BIN_SHIFT = 4;

    // output buffer
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_MODE  = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } mf3_cfg_idx_t;

    typedef enum logic {
        MODE_BOX      = 1'b0,
        MODE_BINOMIAL = 1'b1
    } mf3_mode_t;

    // per-pixel control carried down the pipeline
    typedef struct packed {
        logic              filt;
        logic              pass;
        mf3_mode_t         mode;
        logic [PIX_W-1:0]  pix;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } mf3_tag_t;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              last;
    } mf3_res_t;

    // up to two results written into the output buffer in one cycle
    typedef struct packed {
        logic [1:0]  cnt;
        mf3_res_t    res0;
        mf3_res_t    res1;
    } mf3_push_t;

endpackage

/* hw/rtl/mf3_ifs.sv */
interface mf3_pix_if import mf3_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  in_pixel;

    modport source (output valid, output in_pixel, input ready);
    modport sink (input valid, input in_pixel, output ready);
endinterface

interface mf3_res_if import mf3_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  out_pixel;
    logic [COL_W-1:0]  out_col;
    logic [ROW_W-1:0]  out_row;
    logic              run_last;

    modport source (output valid, output out_pixel, output out_col, output out_row,
                    output run_last, input ready);
    modport sink (input valid, input out_pixel, input out_col, input out_row,
                  input run_last, output ready);
endinterface

interface mf3_cfg_if import mf3_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/mean_filter_3x3_two_kernels_core.sv */
// path: an accepted pixel passes the s1 and s2 window registers, then the output buffer
// throughput: one pixel per clock while no more than six of the 8 output buffer
//   entries are reserved; a pixel that yields two results (right border, bottom row)
//   reserves two entries, so along the bottom row input stalls on the reservation
// reset: rst_n asynchronous, active low; clears counters, window, buffer and sets
//   box mode, 640 x 480; the line store is not cleared; only written data is filtered
module mean_filter_3x3_two_kernels_core import mf3_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic  clk,
    input  logic  rst_n,
    mf3_pix_if.sink    pixels,
    mf3_res_if.source  results,
    mf3_cfg_if.sink    cfg
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic                    mode_reg;
    logic [FWD_W-1:0]        width_reg;
    logic [HGT_W-1:0]        height_reg;

    logic [CW-1:0]           col_count_reg;
    logic [CW-1:0]           col_count_next;
    logic [ROW_W-1:0]        row_count_reg;
    logic [ROW_W-1:0]        row_count_next;
    logic [FIFO_CW-1:0]      pend_reg;
    logic [FIFO_CW-1:0]      pend_next;

    logic [CW:0]             eff_w;
    logic [HGT_W-1:0]        eff_h;
    logic [CW:0]             col_ext;
    logic [CW:0]             col_p1;
    logic [HGT_W-1:0]        row_ext;
    logic [HGT_W-1:0]        row_p1;
    logic                    filt;
    logic                    pass;
    logic [1:0]              n_res;
    logic                    acc;
    logic                    pop;
    mf3_tag_t                tag;

    logic                    sum_valid;
    mf3_tag_t                sum_tag;
    logic [SUM_W-1:0]        sum;
    mf3_push_t               push;
    logic                    not_empty;
    mf3_res_t                head;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_BOX;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_KERNEL_MODE:  mode_reg   <= cfg.data[0];
                CFG_FRAME_WIDTH:  width_reg  <= cfg.data[FWD_W-1:0];
                CFG_FRAME_HEIGHT: height_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    // clamp frame size
    always_comb
    begin
        if (32'(width_reg) < MIN_SIZE)
        begin
            eff_w = (CW+1)'(MIN_SIZE);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            eff_w = (CW+1)'(MAX_WIDTH);
        end
        else
        begin
            eff_w = (CW+1)'(width_reg);
        end

        if (32'(height_reg) < MIN_SIZE)
        begin
            eff_h = HGT_W'(MIN_SIZE);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            eff_h = HGT_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = height_reg;
        end
    end

    // classify the current position
    always_comb
    begin
        col_ext = {1'b0, col_count_reg};
        col_p1  = col_ext + (CW+1)'(1);
        row_ext = {1'b0, row_count_reg};
        row_p1  = row_ext + HGT_W'(1);
        filt    = (row_count_reg >= ROW_W'(2)) && (col_ext >= (CW+1)'(2))
               && (row_ext < eff_h) && (col_ext < eff_w);
        pass    = (row_count_reg == '0) || (col_count_reg == '0)
               || (row_p1 >= eff_h) || (col_p1 >= eff_w);
        n_res   = 2'(filt) + 2'(pass);
    end

    // accept only while the output buffer can take everything in flight
    assign pixels.ready = (pend_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign acc          = pixels.valid && pixels.ready;
    assign pop          = results.valid && results.ready;

    // raster counters and reserved buffer space
    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (acc)
        begin
            if (col_p1 >= eff_w)
            begin
                col_count_next = '0;
                row_count_next = (row_p1 >= eff_h) ? '0 : row_p1[ROW_W-1:0];
            end
            else
            begin
                col_count_next = col_p1[CW-1:0];
            end
        end
        pend_next = pend_reg + (acc ? FIFO_CW'(n_res) : '0) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            pend_reg      <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            pend_reg      <= pend_next;
        end
    end

    // per-pixel control word
    always_comb
    begin
        tag.filt = filt;
        tag.pass = pass;
        tag.mode = mf3_mode_t'(mode_reg);
        tag.pix  = pixels.in_pixel;
        tag.col  = COL_W'(col_count_reg);
        tag.row  = row_count_reg;
    end

    mf3_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .addr      (col_count_reg),
        .tag       (tag),
        .sum_valid (sum_valid),
        .sum_tag   (sum_tag),
        .sum       (sum)
    );

    mf3_kernel u_kernel (
        .sum_valid (sum_valid),
        .sum_tag   (sum_tag),
        .sum       (sum),
        .push      (push)
    );

    mf3_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    // result channel
    assign results.valid     = not_empty;
    assign results.out_pixel = head.pixel;
    assign results.out_col   = head.col;
    assign results.out_row   = head.row;
    assign results.run_last  = head.last;

`ifndef SYNTHESIS
    // reserved space never exceeds the output buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("output reservation exceeds buffer depth");

    // a presented result always belongs to a reserved slot
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (pend_reg != '0))
        else $error("result presented without reservation");

    // a pixel yielding results keeps the reservation nonzero on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (n_res != 2'd0)) |=> (pend_reg != '0))
        else $error("reservation lost after accepting a pixel");
`endif

endmodule

/* hw/rtl/mf3_window.sv */
module mf3_window import mf3_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          acc,
    input  logic [$clog2(MAX_WIDTH)-1:0]  addr,
    input  mf3_tag_t                      tag,
    output logic                          sum_valid,
    output mf3_tag_t                      sum_tag,
    output logic [SUM_W-1:0]              sum
);

    localparam int AW = $clog2(MAX_WIDTH);

    // line store: upper byte two rows up, lower byte one row up
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;

    logic              s1_valid_reg;
    logic [AW-1:0]     s1_addr_reg;
    mf3_tag_t          s1_tag_reg;

    logic [PIX_W-1:0]  win_reg [6];
    logic [PIX_W-1:0]  top;
    logic [PIX_W-1:0]  mid;
    logic [SUM_W-1:0]  box_sum;
    logic [SUM_W-1:0]  bin_sum;

    logic              s2_valid_reg;
    mf3_tag_t          s2_tag_reg;
    logic [SUM_W-1:0]  sum_reg;

    // read at acceptance, write back in the cycle after; consecutive columns never collide
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rd_data_reg <= line_mem[addr];
        end
        if (s1_valid_reg)
        begin
            line_mem[s1_addr_reg] <= {mid, s1_tag_reg.pix};
        end
    end

    assign top = rd_data_reg[2*PIX_W-1:PIX_W];
    assign mid = rd_data_reg[PIX_W-1:0];

    // kernel sums over the window
    always_comb
    begin
        box_sum = SUM_W'(win_reg[0]) + SUM_W'(win_reg[1]) + SUM_W'(win_reg[2])
                + SUM_W'(win_reg[3]) + SUM_W'(win_reg[4]) + SUM_W'(win_reg[5])
                + SUM_W'(top) + SUM_W'(mid) + SUM_W'(s1_tag_reg.pix);
        bin_sum = SUM_W'(win_reg[0]) + (SUM_W'(win_reg[1]) << 1) + SUM_W'(win_reg[2])
                + (SUM_W'(win_reg[3]) << 1) + (SUM_W'(win_reg[4]) << 2)
                + (SUM_W'(win_reg[5]) << 1)
                + SUM_W'(top) + (SUM_W'(mid) << 1) + SUM_W'(s1_tag_reg.pix);
    end

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= acc;
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top;
                win_reg[4] <= mid;
                win_reg[5] <= s1_tag_reg.pix;
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_addr_reg <= addr;
            s1_tag_reg  <= tag;
        end
        if (s1_valid_reg)
        begin
            s2_tag_reg <= s1_tag_reg;
            sum_reg    <= (s1_tag_reg.mode == MODE_BINOMIAL) ? bin_sum : box_sum;
        end
    end

    assign sum_valid = s2_valid_reg;
    assign sum_tag   = s2_tag_reg;
    assign sum       = sum_reg;

endmodule

/* hw/rtl/mf3_kernel.sv */
module mf3_kernel import mf3_pkg::*; (
    input  logic              sum_valid,
    input  mf3_tag_t          sum_tag,
    input  logic [SUM_W-1:0]  sum,
    output mf3_push_t         push
);

    logic [BOX_X_W-1:0]     box_x;
    logic [BOX_PROD_W-1:0]  box_prod;
    logic [SUM_W-1:0]       bin_x;
    logic [PIX_W-1:0]       mean;
    mf3_res_t               filt_res;
    mf3_res_t               pass_res;

    // rounded means: (2*sum+9)/18 by reciprocal, (sum+8)/16 by shift
    always_comb
    begin
        box_x    = {sum, 1'b0} + BOX_BIAS;
        box_prod = BOX_PROD_W'(box_x) * BOX_PROD_W'(BOX_RECIP);
        bin_x    = sum + BIN_BIAS;
        if (sum_tag.mode == MODE_BINOMIAL)
        begin
            mean = bin_x[BIN_SHIFT +: PIX_W];
        end
        else
        begin
            mean = box_prod[BOX_SHIFT +: PIX_W];
        end
    end

    // filtered pixel sits one row up and one column left
    always_comb
    begin
        filt_res.pixel = mean;
        filt_res.col   = sum_tag.col - COL_W'(1);
        filt_res.row   = sum_tag.row - ROW_W'(1);
        filt_res.last  = !sum_tag.pass;
        pass_res.pixel = sum_tag.pix;
        pass_res.col   = sum_tag.col;
        pass_res.row   = sum_tag.row;
        pass_res.last  = 1'b1;
    end

    // order: filtered first, then border copy
    always_comb
    begin
        push.cnt  = 2'd0;
        push.res0 = pass_res;
        push.res1 = pass_res;
        if (sum_valid)
        begin
            if (sum_tag.filt)
            begin
                push.res0 = filt_res;
                push.cnt  = sum_tag.pass ? 2'd2 : 2'd1;
            end
            else if (sum_tag.pass)
            begin
                push.cnt = 2'd1;
            end
        end
    end

endmodule

/* hw/rtl/mf3_out_fifo.sv */
module mf3_out_fifo import mf3_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  mf3_push_t  push,
    input  logic       pop,
    output logic       not_empty,
    output mf3_res_t   head
);

    mf3_res_t              buf_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    wr_ptr_reg;
    logic [FIFO_AW-1:0]    wr_ptr_next;
    logic [FIFO_AW-1:0]    rd_ptr_reg;
    logic [FIFO_AW-1:0]    rd_ptr_next;
    logic [FIFO_CW-1:0]    count_reg;
    logic [FIFO_CW-1:0]    count_next;
    logic                  do_pop;

    assign do_pop = pop && (count_reg != '0);

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(do_pop);
        count_next  = count_reg + FIFO_CW'(push.cnt) - FIFO_CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // up to two writes a cycle, space is reserved upstream
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            buf_mem[wr_ptr_reg] <= push.res0;
        end
        if (push.cnt == 2'd2)
        begin
            buf_mem[wr_ptr_reg + FIFO_AW'(1)] <= push.res1;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = buf_mem[rd_ptr_reg];

endmodule

/* sim/mf3_result_checker.sv */
`timescale 1ns / 100ps

module mf3_result_checker import mf3_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic  clk,
    input  logic  rst_n,
    mf3_pix_if    pixels,
    mf3_res_if    results,
    mf3_cfg_if    cfg,
    output int    error_count,
    output int    pending,
    output int    cur_col,
    output int    cur_row,
    output int    eff_width,
    output int    eff_height
);

    // predictor copy of the line stores, window and position
    logic [PIX_W-1:0]  line_up [MAX_WIDTH];
    logic [PIX_W-1:0]  line_up2 [MAX_WIDTH];
    logic [PIX_W-1:0]  win [6];
    mf3_mode_t         mode_q;
    logic [FWD_W-1:0]  width_q;
    logic [HGT_W-1:0]  height_q;
    int                col_q;
    int                row_q;
    int                errors = 0;

    // filtered and border pixels still to come out of the block
    mf3_res_t          expected_pixels [$];

    function automatic int clamp_width(input logic [FWD_W-1:0] w);
        int v;
        v = w;
        if (v < MIN_SIZE)
        begin
            v = MIN_SIZE;
        end
        if (v > MAX_WIDTH)
        begin
            v = MAX_WIDTH;
        end
        return v;
    endfunction

    function automatic int clamp_height(input logic [HGT_W-1:0] h);
        int v;
        v = h;
        if (v < MIN_SIZE)
        begin
            v = MIN_SIZE;
        end
        if (v > MAX_HEIGHT)
        begin
            v = MAX_HEIGHT;
        end
        return v;
    endfunction

    // window step for one source pixel: queue the results it causes
    task automatic predict_window_results(input logic [PIX_W-1:0] pix);
        int                w;
        int                h;
        int                r;
        int                c;
        int                sum;
        int                n;
        logic [PIX_W-1:0]  above2;
        logic [PIX_W-1:0]  above;
        mf3_res_t          res [2];
        w = clamp_width(width_q);
        h = clamp_height(height_q);
        r = row_q;
        c = col_q;
        n = 0;
        above2 = line_up2[c];
        above = line_up[c];

        // window fully inside the frame: centre pixel is filtered
        if (r >= 2 && c >= 2 && r <= h - 1 && c <= w - 1)
        begin
            if (mode_q == MODE_BOX)
            begin
                sum = win[0] + win[1] + win[2] + win[3] + win[4] + win[5]
                    + above2 + above + pix;
                res[n].pixel = PIX_W'((2 * sum + 9) / 18);
            end
            else
            begin
                sum = win[0] + 2 * win[1] + win[2] + 2 * win[3] + 4 * win[4]
                    + 2 * win[5] + above2 + 2 * above + pix;
                res[n].pixel = PIX_W'((sum + 8) / 16);
            end
            res[n].col = COL_W'(c - 1);
            res[n].row = ROW_W'(r - 1);
            res[n].last = 1'b0;
            n++;
        end

        // border pixel passes through as it arrives
        if (r == 0 || c == 0 || r >= h - 1 || c >= w - 1)
        begin
            res[n].pixel = pix;
            res[n].col = COL_W'(c);
            res[n].row = ROW_W'(r);
            res[n].last = 1'b0;
            n++;
        end

        if (n > 0)
        begin
            res[n - 1].last = 1'b1;
        end
        for (int k = 0; k < n; k++)
        begin
            expected_pixels.push_back(res[k]);
        end

        // shift the window and update the line stores
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = above2;
        win[4] = above;
        win[5] = pix;
        line_up2[c] = above;
        line_up[c] = pix;

        // raster position of the next pixel
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
            begin
                r = 0;
            end
        end
        col_q = c;
        row_q = r;
    endtask

    task automatic compare_field(input string name, input logic [31:0] expd,
                                 input logic [31:0] act);
        if (act !== expd)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, expd, act);
            errors++;
        end
    endtask

    // oldest expectation against the result transaction
    task automatic check_result();
        mf3_res_t exp_r;
        if (expected_pixels.size() == 0)
        begin
            $display("%0t ns: result with none expected, actual pixel %0d col %0d row %0d last %0d",
                     $time, results.out_pixel, results.out_col, results.out_row,
                     results.run_last);
            errors++;
        end
        else
        begin
            exp_r = expected_pixels.pop_front();
            compare_field("out_pixel", exp_r.pixel, results.out_pixel);
            compare_field("out_col", exp_r.col, results.out_col);
            compare_field("out_row", exp_r.row, results.out_row);
            compare_field("run_last", exp_r.last, results.run_last);
        end
    endtask

    // watch all three channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q = MODE_BOX;
            width_q = WIDTH_RESET;
            height_q = HEIGHT_RESET;
            col_q = 0;
            row_q = 0;
            for (int i = 0; i < 6; i++)
            begin
                win[i] = '0;
            end
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                line_up[i] = '0;
                line_up2[i] = '0;
            end
            expected_pixels.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_KERNEL_MODE:  mode_q = mf3_mode_t'(cfg.data[0]);
                    CFG_FRAME_WIDTH:  width_q = cfg.data[FWD_W-1:0];
                    CFG_FRAME_HEIGHT: height_q = cfg.data[HGT_W-1:0];
                    default:          ;
                endcase
            end
            if (pixels.valid && pixels.ready)
            begin
                predict_window_results(pixels.in_pixel);
            end
            if (results.valid && results.ready)
            begin
                check_result();
            end
        end
        error_count <= errors;
        pending <= expected_pixels.size();
        cur_col <= col_q;
        cur_row <= row_q;
        eff_width <= clamp_width(width_q);
        eff_height <= clamp_height(height_q);
    end

endmodule

/* sim/tb_mean_filter_3x3_two_kernels_core.sv */
`timescale 1ns / 100ps

module tb_mean_filter_3x3_two_kernels_core;
    import mf3_pkg::*;

    localparam int MAX_WIDTH = 1024;
    localparam int CLK_HALF = 5;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES = 200;
    localparam int RANDOM_ITEMS = 150;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
    localparam logic [CFG_DATA_W-1:0] CFG_ALL_ONES = 13'h1FFF;

    typedef enum int {
        FILL_WHITE,
        FILL_BLACK,
        FILL_CHECKER,
        FILL_RAMP,
        FILL_EDGES,
        FILL_RANDOM
    } fill_t;

    logic   clk = 1'b0;
    logic   rst_n;
    int     send_idle = 0;
    int     recv_stall = 0;
    int     phase = 0;
    bit     hold_on;
    event   hold_start;
    int     sent_items = 0;
    fill_t  fill = FILL_RANDOM;
    int     fill_idx = 0;

    int     errors;
    int     pending;
    int     cur_col;
    int     cur_row;
    int     eff_width;
    int     eff_height;

    mf3_pix_if pix_ch ();
    mf3_res_if res_ch ();
    mf3_cfg_if cfg_ch ();

    mean_filter_3x3_two_kernels_core #(
        .MAX_WIDTH (MAX_WIDTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    mf3_result_checker #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixels      (pix_ch),
        .results     (res_ch),
        .cfg         (cfg_ch),
        .error_count (errors),
        .pending     (pending),
        .cur_col     (cur_col),
        .cur_row     (cur_row),
        .eff_width   (eff_width),
        .eff_height  (eff_height)
    );

    always #CLK_HALF clk = ~clk;

    // result side: random stalls, or a long hold-off when asked
    always @(posedge clk)
    begin
        res_ch.ready <= !hold_on && ($urandom_range(99) >= recv_stall);
    end

    // long receiver hold-off, counted here
    initial
    begin
        hold_on = 1'b0;
        forever
        begin
            @(hold_start);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on <= 1'b0;
        end
    end

    // run limit
    initial
    begin
        #8_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [PIX_W-1:0] fill_pixel(input fill_t f, input int idx);
        case (f)
            FILL_WHITE:   return 8'hFF;
            FILL_BLACK:   return 8'h00;
            FILL_CHECKER: return idx[0] ? 8'hFF : 8'h00;
            FILL_RAMP:    return PIX_W'(idx * 37);
            FILL_EDGES:   return $urandom_range(1) ? 8'hFF : 8'h00;
            default:      return PIX_W'($urandom_range(255));
        endcase
    endfunction

    // pixels until the position wraps to the start of a frame
    function automatic int pixels_left();
        int row_rest;
        // a column at or beyond the width wraps after one more pixel
        row_rest = (cur_col < eff_width) ? eff_width - cur_col : 1;
        if (cur_row >= eff_height)
        begin
            return row_rest;
        end
        return row_rest + (eff_height - cur_row - 1) * eff_width;
    endfunction

    task automatic set_idle(input int sel);
        case (sel)
            0:       begin send_idle = 0;  recv_stall = 0;  end
            1:       begin send_idle = 51; recv_stall = 0;  end
            2:       begin send_idle = 0;  recv_stall = 51; end
            default: begin send_idle = 15; recv_stall = 15; end
        endcase
    endtask

    // one pixel transaction, with optional idle cycles ahead of it
    task automatic send_pixel(input logic [PIX_W-1:0] value);
        while ($urandom_range(99) < send_idle)
        begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.in_pixel <= value;
        @(posedge clk);
        while (!pix_ch.ready)
        begin
            @(posedge clk);
        end
        sent_items++;
    endtask

    task automatic send_pixels(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_pixel(fill_pixel(fill, fill_idx));
            fill_idx++;
        end
    endtask

    // stop the source and wait until the block has nothing left
    task automatic stop_and_drain();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic complete_frame();
        send_pixels(pixels_left());
        stop_and_drain();
    endtask

    // register transaction; valid stays high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic end_writes();
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // only called at the start of a frame, so the line stores stay valid
    task automatic set_frame(input mf3_mode_t mode, input logic [CFG_DATA_W-1:0] width_raw,
                             input logic [CFG_DATA_W-1:0] height_raw);
        write_reg(CFG_KERNEL_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_FRAME_WIDTH, width_raw);
        write_reg(CFG_FRAME_HEIGHT, height_raw);
        end_writes();
    endtask

    // small random frames, some split by a mode or height change
    task automatic random_frames();
        int w_raw;
        int h_raw;
        int k;
        set_idle(phase % 4);
        phase++;
        case ($urandom_range(9))
            0:       w_raw = $urandom_range(2);
            1:       w_raw = $urandom_range(40, 16);
            default: w_raw = $urandom_range(9, 3);
        endcase
        h_raw = ($urandom_range(5) == 0) ? $urandom_range(2) : $urandom_range(6, 3);
        if ($urandom_range(4) == 0)
        begin
            write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
        end
        set_frame(mf3_mode_t'($urandom_range(1)), CFG_DATA_W'(w_raw), CFG_DATA_W'(h_raw));
        repeat ($urandom_range(2, 1))
        begin
            fill = ($urandom_range(9) < 5) ? fill_t'($urandom_range(4)) : FILL_RANDOM;
            if ($urandom_range(2) == 0)
            begin
                k = $urandom_range(pixels_left() - 1, 1);
                send_pixels(k);
                stop_and_drain();
                write_reg(CFG_KERNEL_MODE, CFG_DATA_W'($urandom_range(1)));
                if ($urandom_range(1))
                begin
                    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(7)));
                end
                end_writes();
            end
            complete_frame();
        end
    endtask

    initial
    begin
        int rand_start;
        rst_n <= 1'b0;
        pix_ch.valid <= 1'b0;
        pix_ch.in_pixel <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_KERNEL_MODE;
        cfg_ch.data <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest frame, brightest image, both kernels; then clamped sizes
        set_frame(MODE_BOX, 13'd3, 13'd3);
        fill = FILL_WHITE;
        complete_frame();
        set_frame(MODE_BINOMIAL, 13'd3, 13'd3);
        complete_frame();
        set_frame(MODE_BOX, 13'd0, 13'd1);
        fill = FILL_CHECKER;
        complete_frame();

        // widest frame, width written at and above the limit, then narrowed in row 0
        set_idle(0);
        write_reg(CFG_FRAME_WIDTH, 13'd1024);
        set_frame(MODE_BOX, CFG_ALL_ONES, 13'd0);
        fill = FILL_RANDOM;
        send_pixels(40);
        stop_and_drain();
        write_reg(CFG_FRAME_WIDTH, 13'd3);
        end_writes();
        complete_frame();

        // tallest frame, cut short by a mode and height rewrite partway
        set_frame(MODE_BINOMIAL, 13'd3, CFG_ALL_ONES);
        send_pixels(30);
        stop_and_drain();
        write_reg(CFG_FRAME_HEIGHT, 13'd5);
        write_reg(CFG_KERNEL_MODE, CFG_DATA_W'(MODE_BOX));
        end_writes();
        complete_frame();

        // receiver held off while the source keeps offering pixels
        set_frame(MODE_BOX, 13'd8, 13'd8);
        -> hold_start;
        complete_frame();

        rand_start = sent_items;
        while (sent_items - rand_start < RANDOM_ITEMS)
        begin
            random_frames();
        end

        if (errors == 0 && pending == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
